>>> sv/grr_pkg.sv
package grr_pkg;

  localparam int unsigned MAX_GLYPH_WIDTH = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned GLYPH_BITS_W = 16;
  localparam int unsigned ATTR_W       = 8;
  localparam int unsigned COORD_W      = 12;
  localparam int unsigned PIXEL_W      = 32;
  localparam int unsigned FMT_W        = 3;
  localparam int unsigned GWIDTH_W     = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 5;

  localparam logic [GWIDTH_W-1:0] GWIDTH_RESET = 5'd8;

  typedef enum logic [FMT_W-1:0] {
    FMT_BGRA32 = 3'd0,
    FMT_RGBA32 = 3'd1,
    FMT_RGB24  = 3'd2,
    FMT_RGB565 = 3'd3,
    FMT_RGB555 = 3'd4
  } pix_fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_GLYPH_WIDTH  = 2'd1
  } cfg_reg_e;

  // One classified glyph row as it travels from the front to the back.
  typedef struct packed {
    logic [GLYPH_BITS_W-1:0] glyph_bits;
    logic [PIXEL_W-1:0]      fg_word;
    logic [PIXEL_W-1:0]      bg_word;
    logic                    fg_we;
    logic                    bg_we;
    logic [COORD_W-1:0]      cell_x;
    logic [COORD_W-1:0]      row_y;
    logic [GWIDTH_W-1:0]     count;
  } grr_item_t;

  typedef struct packed {
    logic       ok;
    logic [31:0] word;
  } packed_color_t;

  // Fixed 16-color text palette as {r, g, b}.
  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:  rgb = 24'h000000;
      4'd1:  rgb = 24'h0000C0;
      4'd2:  rgb = 24'h00C000;
      4'd3:  rgb = 24'h00C0C0;
      4'd4:  rgb = 24'hC00000;
      4'd5:  rgb = 24'hC000C0;
      4'd6:  rgb = 24'hC08000;
      4'd7:  rgb = 24'hC0C0C0;
      4'd8:  rgb = 24'h808080;
      4'd9:  rgb = 24'h0000FF;
      4'd10: rgb = 24'h00FF00;
      4'd11: rgb = 24'h00FFFF;
      4'd12: rgb = 24'hFF0000;
      4'd13: rgb = 24'hFF00FF;
      4'd14: rgb = 24'hFFFF00;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  // Packs a palette color into a little-endian pixel word.
  function automatic packed_color_t pack_color(input logic [FMT_W-1:0] fmt,
                                               input logic [3:0] idx);
    packed_color_t res;
    logic [23:0]   rgb;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    rgb = palette_rgb(idx);
    r   = rgb[23:16];
    g   = rgb[15:8];
    b   = rgb[7:0];
    res.ok = 1'b1;
    unique case (fmt)
      FMT_BGRA32: res.word = {8'hFF, r, g, b};
      FMT_RGBA32: res.word = {8'hFF, b, g, r};
      FMT_RGB24:  res.word = {8'h00, b, g, r};
      FMT_RGB565: res.word = {16'h0000, r[7:3], g[7:2], b[7:3]};
      FMT_RGB555: res.word = {16'h0000, 1'b0, r[7:3], g[7:3], b[7:3]};
      default: begin
        res.ok   = 1'b0;
        res.word = '0;
      end
    endcase
    return res;
  endfunction

endpackage

>>> sv/grr_front.sv
module grr_front import grr_pkg::*; #(
  parameter int unsigned MaxGlyphWidth = MAX_GLYPH_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    start_i,
  input  logic                    full_i,
  input  logic [GLYPH_BITS_W-1:0] glyph_bits_i,
  input  logic [ATTR_W-1:0]       attribute_i,
  input  logic                    draw_background_i,
  input  logic [COORD_W-1:0]      cell_x_i,
  input  logic [COORD_W-1:0]      row_y_i,
  output logic                    push_o,
  output grr_item_t               item_o
);

  logic [FMT_W-1:0]    fmt_q;
  logic [GWIDTH_W-1:0] gwidth_q;
  logic [GWIDTH_W-1:0] width_eff;
  packed_color_t       fg;
  packed_color_t       bg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_W'(FMT_BGRA32);
      gwidth_q <= GWIDTH_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_PIXEL_FORMAT) begin
        fmt_q <= cfg_data_i[FMT_W-1:0];
      end else if (cfg_index_i == REG_GLYPH_WIDTH) begin
        gwidth_q <= cfg_data_i[GWIDTH_W-1:0];
      end
    end
  end

  always_comb begin
    if (gwidth_q == '0) begin
      width_eff = GWIDTH_W'(1);
    end else if (gwidth_q > GWIDTH_W'(MaxGlyphWidth)) begin
      width_eff = GWIDTH_W'(MaxGlyphWidth);
    end else begin
      width_eff = gwidth_q;
    end
  end

  assign fg = pack_color(fmt_q, attribute_i[3:0]);
  assign bg = pack_color(fmt_q, {1'b0, attribute_i[6:4]});

  assign push_o = start_i && !full_i;

  always_comb begin
    item_o.glyph_bits = glyph_bits_i;
    item_o.fg_word    = fg.word;
    item_o.bg_word    = bg.word;
    item_o.fg_we      = fg.ok;
    item_o.bg_we      = bg.ok && draw_background_i;
    item_o.cell_x     = cell_x_i;
    item_o.row_y      = row_y_i;
    item_o.count      = width_eff;
  end

endmodule

>>> sv/grr_queue.sv
module grr_queue import grr_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  grr_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output grr_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grr_item_t        mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> sv/grr_back.sv
module grr_back import grr_pkg::*; #(
  parameter int unsigned MaxGlyphWidth = MAX_GLYPH_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  grr_item_t            item_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [COORD_W-1:0]   pixel_x_o,
  output logic [COORD_W-1:0]   pixel_y_o,
  output logic [PIXEL_W-1:0]   pixel_value_o,
  output logic                 write_enable_o,
  output logic                 last_in_row_o
);

  localparam int unsigned CntW = $clog2(MaxGlyphWidth + 1);

  logic                    active_q;
  logic [GLYPH_BITS_W-1:0] shift_q;
  logic [CntW-1:0]         cnt_q;
  logic [COORD_W-1:0]      x_q;
  logic [COORD_W-1:0]      y_q;
  logic [PIXEL_W-1:0]      fg_q;
  logic [PIXEL_W-1:0]      bg_q;
  logic                    fg_we_q;
  logic                    bg_we_q;
  logic                    last;
  logic                    pix_set;
  logic                    pix_we;

  logic                    out_valid_q;
  logic [COORD_W-1:0]      out_x_q;
  logic [COORD_W-1:0]      out_y_q;
  logic [PIXEL_W-1:0]      out_value_q;
  logic                    out_we_q;
  logic                    out_last_q;

  assign last    = (cnt_q == CntW'(1));
  assign pop_o   = valid_i && (!active_q || last);
  assign pix_set = shift_q[GLYPH_BITS_W-1];
  assign pix_we  = pix_set ? fg_we_q : bg_we_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (active_q && last) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      shift_q <= item_i.glyph_bits;
      cnt_q   <= CntW'(item_i.count);
      x_q     <= item_i.cell_x;
      y_q     <= item_i.row_y;
      fg_q    <= item_i.fg_word;
      bg_q    <= item_i.bg_word;
      fg_we_q <= item_i.fg_we;
      bg_we_q <= item_i.bg_we;
    end else if (active_q) begin
      shift_q <= {shift_q[GLYPH_BITS_W-2:0], 1'b0};
      cnt_q   <= cnt_q - CntW'(1);
      x_q     <= x_q + COORD_W'(1);
    end
    if (active_q) begin
      out_x_q     <= x_q;
      out_y_q     <= y_q;
      out_we_q    <= pix_we;
      out_value_q <= pix_we ? (pix_set ? fg_q : bg_q) : '0;
      out_last_q  <= last;
    end
  end

  assign result_valid_o = out_valid_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign pixel_value_o  = out_value_q;
  assign write_enable_o = out_we_q;
  assign last_in_row_o  = out_last_q;

endmodule

>>> sv/glyph_row_rasterizer.sv
// Glyph row rasterizer: turns one row of a text-mode character glyph into a
// stream of packed pixels, one pixel per clock cycle.
// Input channel: a row is transferred at a rising edge where start_i is high
// and busy_o is low. It carries the 16-bit glyph row (leftmost pixel in the
// top bit), the text attribute, the draw-background flag and the position.
// Configuration channel: cfg_index_i selects the pixel format (index 0) or
// the glyph width (index 1); a write is taken whenever cfg_valid_i is high,
// since cfg_ready_o is tied high. Other indexes are ignored. Write only while
// the block is idle.
// Result channel: each pixel appears for exactly one cycle with
// result_valid_o high; the receiver cannot stall the stream.
// A transferred row is stored in the queue and loaded into the back-end
// emitter; each pixel then passes the output register. The single pixel
// emitter draws one row at a time, one pixel for each column of the glyph
// width (8 by default). A two-entry queue lets new rows be transferred while
// the current one is drawn, and consecutive rows come out without gaps.
// busy_o is high while the queue is full. Reset clears the queue and the
// emitter and restores BGRA32 and a width of eight pixels.
module glyph_row_rasterizer import grr_pkg::*; #(
  parameter int unsigned MaxGlyphWidth = MAX_GLYPH_WIDTH,
  parameter int unsigned QueueDepth    = QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [GLYPH_BITS_W-1:0] glyph_bits_i,
  input  logic [ATTR_W-1:0]       attribute_i,
  input  logic                    draw_background_i,
  input  logic [COORD_W-1:0]      cell_x_i,
  input  logic [COORD_W-1:0]      row_y_i,
  output logic                    result_valid_o,
  output logic [COORD_W-1:0]      pixel_x_o,
  output logic [COORD_W-1:0]      pixel_y_o,
  output logic [PIXEL_W-1:0]      pixel_value_o,
  output logic                    write_enable_o,
  output logic                    last_in_row_o
);

  logic      push;
  logic      full;
  logic      pop;
  logic      q_valid;
  grr_item_t push_item;
  grr_item_t head_item;

  assign busy_o = full;

  // The front end holds the configuration, clamps the width and converts
  // both attribute colors to pixel words as the row is transferred.
  grr_front #(
    .MaxGlyphWidth(MaxGlyphWidth)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start_i          (start_i),
    .full_i           (full),
    .glyph_bits_i     (glyph_bits_i),
    .attribute_i      (attribute_i),
    .draw_background_i(draw_background_i),
    .cell_x_i         (cell_x_i),
    .row_y_i          (row_y_i),
    .push_o           (push),
    .item_o           (push_item)
  );

  // Short queue of classified rows between the two halves.
  grr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (head_item)
  );

  // The back end walks the row one pixel per cycle and loads the next row
  // in the same cycle as it emits the last pixel of the current one.
  grr_back #(
    .MaxGlyphWidth(MaxGlyphWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_value_o (pixel_value_o),
    .write_enable_o(write_enable_o),
    .last_in_row_o (last_in_row_o)
  );

endmodule

>>> sv/grr_checker.sv
module grr_checker import grr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  result_valid_o,
  input logic [COORD_W-1:0]    pixel_x_o,
  input logic [COORD_W-1:0]    pixel_y_o,
  input logic [PIXEL_W-1:0]    pixel_value_o,
  input logic                  write_enable_o,
  input logic                  last_in_row_o
);

  // A row is never broken up: a pixel that is not the last is followed
  // directly by the next one.
  a_row_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_in_row_o |=> result_valid_o)
    else $error("glyph row interrupted");

  a_column_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_in_row_o |=>
      pixel_x_o == COORD_W'($past(pixel_x_o) + COORD_W'(1)))
    else $error("pixel column did not advance by one");

  a_row_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_in_row_o |=> pixel_y_o == $past(pixel_y_o))
    else $error("pixel row changed within a glyph row");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !write_enable_o |-> pixel_value_o == '0)
    else $error("skipped pixel carries a nonzero value");

endmodule

bind glyph_row_rasterizer grr_checker u_grr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .result_valid_o(result_valid_o),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_value_o (pixel_value_o),
  .write_enable_o(write_enable_o),
  .last_in_row_o (last_in_row_o)
);
